>>> src/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
package bpc_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_A0  = 3'd0,
      REG_B1  = 3'd1,
      REG_B2  = 3'd2,
      REG_C12 = 3'd3,
      REG_C11 = 3'd4,
      REG_C22 = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] a0;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] c12;
      logic signed [15:0] c11;
      logic signed [15:0] c22;
   } bpc_coef_type;

   // Hand-off from the polynomial pipe to the scaling pipe.
   typedef struct packed {
      logic               valid;
      logic signed [31:0] prod;
   } bpc_prod_type;

   localparam logic signed [17:0] SCALE_SPAN = 18'sd65000;
   localparam logic [31:0]        SCALE_BASE = 32'd50000;

   // Division by 1023 as a multiply by ceil(2^41 / 1023) and a shift by 41.
   // The result is exact for every dividend up to 2^31.
   localparam logic [31:0]        RECIP      = 32'd2149582851;
   localparam int                 RECIP_SHIFT = 41;
   localparam int                 QUOT_W     = 22;

endpackage

>>> src/bpc_poly.sv
// Five-stage pipeline for the compensation polynomial and the pascal span product.
module bpc_poly
   import bpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [15:0]  pressure_raw,
   input  logic [15:0]  temp_raw,
   input  bpc_coef_type coef,
   output bpc_prod_type prod_out
);

   // Stage 1: coefficient products with the ADC codes.
   logic               v1_ff;
   logic [9:0]         padc1_ff, tadc1_ff;
   logic signed [26:0] c11x1_ff, c12x2_ff, c22x2_ff;
   logic signed [26:0] c11x1_in, c12x2_in, c22x2_in;

   // Stage 2: a11 and a2.
   logic               v2_ff;
   logic [9:0]         padc2_ff, tadc2_ff;
   logic signed [26:0] c12x2_2_ff;
   logic signed [17:0] a11_ff, a11_in;
   logic signed [15:0] a2_ff, a2_in;
   logic signed [31:0] s2_sum_a, s2_sum_b;

   // Stage 3: a1 and a2x2.
   logic               v3_ff;
   logic [9:0]         padc3_ff;
   logic signed [20:0] a1_ff, a1_in;
   logic signed [26:0] a2x2_ff, a2x2_in;
   logic signed [31:0] s3_sum;

   // Stage 4: y1.
   logic               v4_ff;
   logic signed [26:0] a2x2_4_ff;
   logic signed [21:0] y1_ff, y1_in;
   logic signed [31:0] a1x1, s4_sum;

   // Stage 5: pcomp and the span product, wrapped to 32 bits.
   logic               v5_ff;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [31:0] s5_sum;
   logic signed [18:0] pcomp;
   logic signed [36:0] span_full;

   logic [9:0] padc_in, tadc_in;

   always_comb begin
      padc_in  = pressure_raw[15:6];
      tadc_in  = temp_raw[15:6];
      c11x1_in = coef.c11 * $signed({1'b0, padc_in});
      c12x2_in = coef.c12 * $signed({1'b0, tadc_in});
      c22x2_in = coef.c22 * $signed({1'b0, tadc_in});

      s2_sum_a = {{2{coef.b1[15]}}, coef.b1, 14'b0} + 32'(c11x1_ff);
      a11_in   = s2_sum_a[31:14];
      // The halving is done on the signed product before it is widened.
      s2_sum_b = {{1{coef.b2[15]}}, coef.b2, 15'b0} + 32'(c22x2_ff >>> 1);
      a2_in    = s2_sum_b[31:16];

      s3_sum   = {{3{a11_ff[17]}}, a11_ff, 11'b0} + 32'(c12x2_2_ff);
      a1_in    = s3_sum[31:11];
      a2x2_in  = a2_ff * $signed({1'b0, tadc2_ff});

      a1x1     = a1_ff * $signed({1'b0, padc3_ff});
      s4_sum   = {{6{coef.a0[15]}}, coef.a0, 10'b0} + a1x1;
      y1_in    = s4_sum[31:10];

      s5_sum    = {y1_ff, 10'b0} + 32'(a2x2_4_ff);
      pcomp     = s5_sum[31:13];
      span_full = pcomp * SCALE_SPAN;
      prod_in   = span_full[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         padc1_ff   <= padc_in;
         tadc1_ff   <= tadc_in;
         c11x1_ff   <= c11x1_in;
         c12x2_ff   <= c12x2_in;
         c22x2_ff   <= c22x2_in;
         padc2_ff   <= padc1_ff;
         tadc2_ff   <= tadc1_ff;
         c12x2_2_ff <= c12x2_ff;
         a11_ff     <= a11_in;
         a2_ff      <= a2_in;
         padc3_ff   <= padc2_ff;
         a1_ff      <= a1_in;
         a2x2_ff    <= a2x2_in;
         a2x2_4_ff  <= a2x2_ff;
         y1_ff      <= y1_in;
         prod_ff    <= prod_in;
      end
   end

   assign prod_out.valid = v5_ff;
   assign prod_out.prod  = prod_ff;

endmodule

>>> src/bpc_div.sv
// Three-stage signed division by 1023 and pascal offset, ending in the output register.
module bpc_div
   import bpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  bpc_prod_type prod_in,
   output logic         out_valid,
   output logic [31:0]  pressure_pa
);

   // Stage 6: sign and magnitude. The magnitude of -2^31 is 2^31, which fits.
   logic        v6_ff, neg6_ff;
   logic [31:0] mag_ff, mag_in;

   // Stage 7: quotient of the magnitude by reciprocal multiply.
   logic              v7_ff, neg7_ff;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [63:0]       recip_full;

   // Stage 8: signed quotient plus offset.
   logic        v8_ff;
   logic [31:0] res_ff, res_in;

   always_comb begin
      mag_in     = prod_in.prod[31] ? (~prod_in.prod + 32'd1) : prod_in.prod;
      recip_full = mag_ff * RECIP;
      quot_in    = recip_full[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
      res_in     = (neg7_ff ? (32'd0 - 32'(quot_ff)) : 32'(quot_ff)) + SCALE_BASE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= prod_in.valid;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg6_ff <= prod_in.prod[31];
         mag_ff  <= mag_in;
         neg7_ff <= neg6_ff;
         quot_ff <= quot_in;
         res_ff  <= res_in;
      end
   end

   assign out_valid   = v8_ff;
   assign pressure_pa = res_ff;

   // A valid quotient never exceeds 2^31 / 1023.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      v7_ff |-> (quot_ff <= QUOT_W'(2099202)))
      else $error("quotient out of range");

   // A stalled pipe keeps its valid bits.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(v6_ff) && $stable(v7_ff) && $stable(v8_ff)))
      else $error("valid bits moved during a stall");

   // An advancing pipe moves the last valid bit into the output register.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (en && v7_ff) |=> v8_ff)
      else $error("item lost between quotient and output stage");

endmodule

>>> src/barometric_pressure_compensation.sv
// Throughput: one item per cycle; all eight stages advance together, and a low rsp_tready
// with a full output register freezes every stage, so req_tready follows rsp_tready then.
// An accepted req_ item passes through the bpc_poly stages and then the bpc_div stages,
// and rsp_tvalid rises when it reaches the output register. Reset (synchronous) clears all
// stage valid bits and sets the six coefficients to zero. Coefficient writes take effect at
// the next cycle; the user must make them while no item is in flight (the block does not enforce it).
module barometric_pressure_compensation
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] pressure_raw, [31:16] temp_raw
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] pressure_pa
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   bpc_coef_type coef_ff;
   bpc_prod_type prod;
   logic         advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            REG_A0:  coef_ff.a0  <= csr_wdata;
            REG_B1:  coef_ff.b1  <= csr_wdata;
            REG_B2:  coef_ff.b2  <= csr_wdata;
            REG_C12: coef_ff.c12 <= csr_wdata;
            REG_C11: coef_ff.c11 <= csr_wdata;
            REG_C22: coef_ff.c22 <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipe moves whenever the output register is empty or being drained.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   bpc_poly u_poly (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_valid     (req_tvalid),
      .pressure_raw (req_tdata[15:0]),
      .temp_raw     (req_tdata[31:16]),
      .coef         (coef_ff),
      .prod_out     (prod)
   );

   bpc_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (advance),
      .prod_in     (prod),
      .out_valid   (rsp_tvalid),
      .pressure_pa (rsp_tdata)
   );

endmodule
